/* rtl/sucd_pkg.sv */
// ----------------------------------------------------------------------------
// sucd_pkg
// shared types and constants for the serial unlock command decoder
// ----------------------------------------------------------------------------
package sucd_pkg;

    localparam int CHAR_W   = 8;
    localparam int PERIOD_W = 16;
    localparam int CFG_IDX_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEP  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FLOOR = 8'd1;

    // reset values
    localparam logic [PERIOD_W-1:0] STEP_RESET   = 16'd2000;
    localparam logic [PERIOD_W-1:0] FLOOR_RESET  = 16'd4000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10000;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 16'hFFFF;

    // character codes
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_B     = 8'h42;
    localparam logic [CHAR_W-1:0] CH_C     = 8'h43;
    localparam logic [CHAR_W-1:0] CH_L     = 8'h4C;
    localparam logic [CHAR_W-1:0] CH_P_UC  = 8'h50;
    localparam logic [CHAR_W-1:0] CH_P_LC  = 8'h70;
    localparam logic [CHAR_W-1:0] CH_S_UC  = 8'h53;
    localparam logic [CHAR_W-1:0] CH_S_LC  = 8'h73;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_UNLOCKED = 3'd1,
        ST_LOCKED   = 3'd2,
        ST_PAUSED   = 3'd3,
        ST_RUNNING  = 3'd4,
        ST_FASTER   = 3'd5,
        ST_SLOWER   = 3'd6,
        ST_INVALID  = 3'd7
    } status_t;

    // unlock progress codes
    typedef enum logic [1:0] {
        PROG_IDLE     = 2'd0,
        PROG_GOT_A    = 2'd1,
        PROG_GOT_B    = 2'd2,
        PROG_UNLOCKED = 2'd3
    } progress_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] step;
        logic [PERIOD_W-1:0] floor;
    } cfg_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic                is_unlocked;
        logic                is_running;
        status_t             status;
    } result_t;

endpackage

/* rtl/sucd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sucd_cfg_regs
// period step and floor registers behind the configuration write channel
// ----------------------------------------------------------------------------
module sucd_cfg_regs
    import sucd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [PERIOD_W-1:0]  wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step  <= STEP_RESET;
            cfg_reg.floor <= FLOOR_RESET;
        end
        else if (wr_en)
        begin
            // unknown indexes are dropped
            if (wr_index == CFG_IDX_STEP)
            begin
                cfg_reg.step <= wr_data;
            end
            else if (wr_index == CFG_IDX_FLOOR)
            begin
                cfg_reg.floor <= wr_data;
            end
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/sucd_decode.sv */
// ----------------------------------------------------------------------------
// sucd_decode
// character decode, unlock tracking and run / period state
// ----------------------------------------------------------------------------
module sucd_decode
    import sucd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [CHAR_W-1:0] ch,
    input  cfg_t              cfg,
    output result_t           result
);

    progress_t             progress_reg,  progress_next;
    logic                  running_reg,   running_next;
    logic [PERIOD_W-1:0]   period_reg,    period_next;
    status_t               status;
    logic [PERIOD_W-1:0]   raised;
    logic [PERIOD_W:0]     sum;
    logic                  blank;

    assign blank  = (ch == CH_CR) || (ch == CH_LF) || (ch == CH_SPACE);
    assign raised = (period_reg < cfg.floor) ? cfg.floor : period_reg;
    assign sum    = {1'b0, raised} + {1'b0, cfg.step};

    always_comb
    begin
        progress_next = progress_reg;
        running_next  = running_reg;
        period_next   = period_reg;
        status        = ST_NONE;
        if (blank)
        begin
            status = ST_NONE;
        end
        else if (progress_reg != PROG_UNLOCKED)
        begin
            priority if (progress_reg == PROG_IDLE && ch == CH_A)
            begin
                progress_next = PROG_GOT_A;
            end
            else if (progress_reg == PROG_GOT_A && ch == CH_B)
            begin
                progress_next = PROG_GOT_B;
            end
            else if (progress_reg == PROG_GOT_B && ch == CH_C)
            begin
                progress_next = PROG_UNLOCKED;
                status        = ST_UNLOCKED;
            end
            else
            begin
                progress_next = PROG_IDLE;
                status        = ST_LOCKED;
            end
        end
        else
        begin
            priority if (ch == CH_P_UC || ch == CH_P_LC)
            begin
                running_next = 1'b0;
                status       = ST_PAUSED;
            end
            else if (ch == CH_S_UC || ch == CH_S_LC)
            begin
                running_next = 1'b1;
                status       = ST_RUNNING;
            end
            else if (ch == CH_PLUS)
            begin
                // saturate at zero
                period_next = (raised >= cfg.step) ? (raised - cfg.step) : '0;
                status      = ST_FASTER;
            end
            else if (ch == CH_MINUS)
            begin
                period_next = raised;
                if (raised > cfg.floor)
                begin
                    period_next = sum[PERIOD_W] ? PERIOD_MAX : sum[PERIOD_W-1:0];
                    status      = ST_SLOWER;
                end
            end
            else if (ch == CH_L)
            begin
                progress_next = PROG_IDLE;
                status        = ST_LOCKED;
            end
            else
            begin
                status = ST_INVALID;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            progress_reg <= PROG_IDLE;
            running_reg  <= 1'b0;
            period_reg   <= PERIOD_RESET;
        end
        else if (advance)
        begin
            progress_reg <= progress_next;
            running_reg  <= running_next;
            period_reg   <= period_next;
        end
    end

    assign result.status      = status;
    assign result.is_running  = running_next;
    assign result.is_unlocked = (progress_next == PROG_UNLOCKED);
    assign result.period      = period_next;

endmodule

/* rtl/serial_unlock_command_decoder.sv */
// ----------------------------------------------------------------------------
// serial_unlock_command_decoder
// a taken request passes through the input register, then the result register, to the master side
// throughput: one character per cycle while the master side is not stalled, set by the single decode stage
// the input register refills in the same cycle its item moves on
// reset: asynchronous, active low; locked, paused, period 10000, step 2000,
// floor 4000, both pipeline registers empty
// ----------------------------------------------------------------------------
module serial_unlock_command_decoder
    import sucd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // character stream in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [7:0] char_in
    // result stream out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,    // [2:0] status, [3] is_running,
                                             // [4] is_unlocked,
                                             // [20:5] timer_period_out, rest 0
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PERIOD_W-1:0]  cfg_data
);

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;
    logic              advance;
    cfg_t              cfg;
    result_t           result;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    sucd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // the held character moves on when the output register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    // input register takes a new request when empty or emptying this cycle
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
        end
    end

    // decode and state update happen together as the character advances
    sucd_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .ch      (in_char_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg.period, out_data_reg.is_unlocked,
                       out_data_reg.is_running, out_data_reg.status};

endmodule

/* rtl/sucd_checker.sv */
// ----------------------------------------------------------------------------
// sucd_checker
// port-level checks on the result stream of the decoder
// ----------------------------------------------------------------------------
module sucd_checker
    import sucd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a lock report never says unlocked
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] == ST_LOCKED |-> !m_tdata[4])
        else $error("locked status with unlocked flag");

    // unlock and command reports only come while unlocked
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == ST_UNLOCKED || m_tdata[2:0] == ST_PAUSED ||
                     m_tdata[2:0] == ST_RUNNING || m_tdata[2:0] == ST_FASTER ||
                     m_tdata[2:0] == ST_SLOWER || m_tdata[2:0] == ST_INVALID)
        |-> m_tdata[4])
        else $error("command status while locked");

    // pause and run reports agree with the run flag
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == ST_PAUSED || m_tdata[2:0] == ST_RUNNING)
        |-> m_tdata[3] == (m_tdata[2:0] == ST_RUNNING))
        else $error("run flag disagrees with status");

    // padding stays zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:21] == 3'b000)
        else $error("nonzero padding in result");

endmodule

bind serial_unlock_command_decoder sucd_checker u_sucd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
